// ===== rtl/kbp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kbp_pkg
// Types and constants shared by the keyboard packet parser modules.
// ----------------------------------------------------------------------------
package kbp_pkg;

	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_HARVEST = 1'b1;

	localparam logic [1:0] KIND_KEY = 2'd0;
	localparam logic [1:0] KIND_BTN = 2'd1;
	localparam logic [1:0] KIND_JOY = 2'd2;
	localparam logic [1:0] KIND_MOT = 2'd3;

	localparam logic [7:0] HDR_STATUS   = 8'hF6;
	localparam logic [7:0] HDR_ABS      = 8'hF7;
	localparam logic [7:0] HDR_REL_BASE = 8'hF8;
	localparam logic [7:0] HDR_CLOCK    = 8'hFC;
	localparam logic [7:0] HDR_JOYS     = 8'hFD;
	localparam logic [7:0] HDR_JOY0     = 8'hFE;
	localparam logic [7:0] HDR_JOY1     = 8'hFF;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]         event_kind;
		logic [7:0]         event_code;
		logic signed [15:0] motion_dx;
		logic signed [15:0] motion_dy;
	} evt_t;

	function automatic logic [2:0] header_length(input logic [7:0] h);
		logic [2:0] len;
		len = 3'd0;
		if (h[7:2] == HDR_REL_BASE[7:2]) begin
			len = 3'd2;
		end else begin
			unique case (h)
				HDR_STATUS: len = 3'd7;
				HDR_ABS:    len = 3'd5;
				HDR_CLOCK:  len = 3'd6;
				HDR_JOYS:   len = 3'd2;
				HDR_JOY0:   len = 3'd1;
				HDR_JOY1:   len = 3'd1;
				default:    len = 3'd0;
			endcase
		end
		return len;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/kbp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kbp_parser
// Packet state, motion totals and per-transaction event decode.
// ----------------------------------------------------------------------------
module kbp_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         fire,
	input  wire kbp_pkg::req_t item,
	output logic              res_valid,
	output kbp_pkg::evt_t     res
);
	import kbp_pkg::*;

	logic [2:0]  bytes_left_q,    bytes_left_d;
	logic [7:0]  packet_header_q, packet_header_d;
	logic [2:0]  payload_index_q, payload_index_d;
	logic [7:0]  first_payload_q, first_payload_d;
	logic [7:0]  second_payload_q, second_payload_d;
	logic [1:0]  last_buttons_q,  last_buttons_d;
	logic [15:0] dx_total_q,      dx_total_d;
	logic [15:0] dy_total_q,      dy_total_d;
	logic [7:0]  b;
	logic [2:0]  bl_dec;
	logic [1:0]  btn;

	assign b      = item.rx_byte;
	assign bl_dec = bytes_left_q - 3'd1;
	assign btn    = packet_header_q[1:0];

	always_comb begin
		bytes_left_d     = bytes_left_q;
		packet_header_d  = packet_header_q;
		payload_index_d  = payload_index_q;
		first_payload_d  = first_payload_q;
		second_payload_d = second_payload_q;
		last_buttons_d   = last_buttons_q;
		dx_total_d       = dx_total_q;
		dy_total_d       = dy_total_q;
		res_valid        = 1'b0;
		res              = '0;
		if (item.action == ACT_HARVEST) begin
			res_valid      = 1'b1;
			res.event_kind = KIND_MOT;
			res.motion_dx  = dx_total_q;
			res.motion_dy  = dy_total_q;
			dx_total_d     = '0;
			dy_total_d     = '0;
		end else if (bytes_left_q != 3'd0) begin
			if (payload_index_q == 3'd0) begin
				first_payload_d = b;
			end else if (payload_index_q == 3'd1) begin
				second_payload_d = b;
			end
			payload_index_d = payload_index_q + 3'd1;
			bytes_left_d    = bl_dec;
			if (bl_dec == 3'd0) begin
				if (packet_header_q[7:2] == HDR_REL_BASE[7:2]) begin
					dx_total_d = dx_total_q + {{8{first_payload_d[7]}}, first_payload_d};
					dy_total_d = dy_total_q + {{8{second_payload_d[7]}}, second_payload_d};
					if (btn != last_buttons_q) begin
						last_buttons_d = btn;
						res_valid      = 1'b1;
						res.event_kind = KIND_BTN;
						res.event_code = {6'd0, btn};
					end
				end else if (packet_header_q == HDR_JOYS) begin
					res_valid      = 1'b1;
					res.event_kind = KIND_JOY;
					res.event_code = second_payload_d;
				end else if (packet_header_q == HDR_JOY1) begin
					res_valid      = 1'b1;
					res.event_kind = KIND_JOY;
					res.event_code = first_payload_d;
				end
			end
		end else if (b >= HDR_STATUS) begin
			packet_header_d = b;
			payload_index_d = 3'd0;
			bytes_left_d    = header_length(b);
		end else begin
			res_valid      = 1'b1;
			res.event_kind = KIND_KEY;
			res.event_code = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q    <= '0;
			packet_header_q <= '0;
			payload_index_q <= '0;
			last_buttons_q  <= '0;
			dx_total_q      <= '0;
			dy_total_q      <= '0;
		end else if (fire) begin
			bytes_left_q    <= bytes_left_d;
			packet_header_q <= packet_header_d;
			payload_index_q <= payload_index_d;
			last_buttons_q  <= last_buttons_d;
			dx_total_q      <= dx_total_d;
			dy_total_q      <= dy_total_d;
		end
	end

	// payload bytes: no reset, always written before use
	always_ff @(posedge clk) begin
		if (fire) begin
			first_payload_q  <= first_payload_d;
			second_payload_q <= second_payload_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kbp_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kbp_out_reg
// Result register on the event channel.
// ----------------------------------------------------------------------------
module kbp_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire kbp_pkg::evt_t res,
	input  wire logic          stall,
	output logic               free,
	output logic               valid,
	output kbp_pkg::evt_t      data
);
	import kbp_pkg::*;

	logic valid_q;
	evt_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/keyboard_packet_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyboard_packet_parser
// Turns the keyboard-controller byte stream into key, button, joystick and
// motion-total events.
//
// req channel: one transaction is a received byte or a harvest request.
// evt channel: zero or one event per req transaction, in order.
// A transaction lands in an input register, is decoded against the packet
// state once the result register is free, and its event is written to the
// result register, which drives evt_valid. One transaction per cycle is
// sustained while the result register is not stalled; the decode and the
// 16-bit adds are combinational.
// Packet bytes and dropped packets give no event and retire without a slot.
// Reset clears packet state, button history and the motion totals; both
// channels come up empty.
// When evt_stall is high a full result register holds; the input register
// still fills, and req_stall rises only once both are occupied.
// ----------------------------------------------------------------------------
module keyboard_packet_parser (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire kbp_pkg::req_t req,
	output logic               evt_valid,
	input  wire logic          evt_stall,
	output kbp_pkg::evt_t      evt
);
	import kbp_pkg::*;

	logic valid_s1;
	req_t item_s1;
	logic out_free;
	logic fire;
	logic res_valid;
	evt_t res;

	assign fire      = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			item_s1 <= req;
		end
	end

	kbp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	kbp_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire && res_valid),
		.res    (res),
		.stall  (evt_stall),
		.free   (out_free),
		.valid  (evt_valid),
		.data   (evt)
	);

endmodule
`default_nettype wire

// ===== rtl/kbp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kbp_checker
// Port-level checks on the keyboard packet parser.
// ----------------------------------------------------------------------------
module kbp_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_stall,
	input wire logic          evt_valid,
	input wire logic          evt_stall,
	input wire kbp_pkg::evt_t evt
);
	import kbp_pkg::*;

	// back pressure only propagates from a full, stalled event register
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (evt_valid && evt_stall))
		else $error("req_stall without stalled event");

	a_motion_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt.event_kind != KIND_MOT)) |->
			(evt.motion_dx == 16'sd0 && evt.motion_dy == 16'sd0))
		else $error("motion fields set on non-motion event");

	a_motion_code: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt.event_kind == KIND_MOT)) |-> (evt.event_code == 8'd0))
		else $error("motion event with nonzero code");

	a_key_range: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt.event_kind == KIND_KEY)) |-> (evt.event_code < HDR_STATUS))
		else $error("key event carries a header byte");

	a_btn_range: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid && (evt.event_kind == KIND_BTN)) |-> (evt.event_code[7:2] == 6'd0))
		else $error("button event out of range");

endmodule

bind keyboard_packet_parser kbp_checker u_kbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_stall (req_stall),
	.evt_valid (evt_valid),
	.evt_stall (evt_stall),
	.evt       (evt)
);
`default_nettype wire

// ===== tb/kbp_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// kbp_tb_pkg
// Event tracker for the keyboard packet parser testbench. It keeps its own
// copy of the packet state, the button history and the motion totals,
// predicts the event of every accepted transaction and checks each event
// the block delivers against the oldest prediction.
// ----------------------------------------------------------------------------
package kbp_tb_pkg;

	import kbp_pkg::*;

	class kbp_event_tracker;
		logic [2:0]  bytes_left;
		logic [7:0]  header;
		logic [2:0]  pay_idx;
		logic [7:0]  pay0;
		logic [7:0]  pay1;
		logic [1:0]  buttons;
		logic [15:0] dx_sum;
		logic [15:0] dy_sum;
		evt_t        expected_q[$];
		int          errors;

		function new();
			bytes_left = '0;
			header     = '0;
			pay_idx    = '0;
			pay0       = '0;
			pay1       = '0;
			buttons    = '0;
			dx_sum     = '0;
			dy_sum     = '0;
			errors     = 0;
		endfunction

		static function logic is_rel(logic [7:0] h);
			return h inside {[HDR_REL_BASE : HDR_REL_BASE + 8'd3]};
		endfunction

		static function logic [2:0] packet_length(logic [7:0] h);
			logic [2:0] len;
			len = 3'd0;
			if (is_rel(h)) begin
				len = 3'd2;
			end else begin
				case (h)
					HDR_STATUS: len = 3'd7;
					HDR_ABS:    len = 3'd5;
					HDR_CLOCK:  len = 3'd6;
					HDR_JOYS:   len = 3'd2;
					HDR_JOY0:   len = 3'd1;
					HDR_JOY1:   len = 3'd1;
					default:    len = 3'd0;
				endcase
			end
			return len;
		endfunction

		function void push_event(logic [1:0] kind, logic [7:0] code,
				logic [15:0] dx, logic [15:0] dy);
			evt_t e;
			e.event_kind = kind;
			e.event_code = code;
			e.motion_dx  = dx;
			e.motion_dy  = dy;
			expected_q.push_back(e);
		endfunction

		function void note_request(req_t r);
			logic [1:0] btn;
			if (r.action == ACT_HARVEST) begin
				push_event(KIND_MOT, 8'h00, dx_sum, dy_sum);
				dx_sum = '0;
				dy_sum = '0;
				return;
			end
			if (bytes_left != 3'd0) begin
				if (pay_idx == 3'd0) begin
					pay0 = r.rx_byte;
				end else if (pay_idx == 3'd1) begin
					pay1 = r.rx_byte;
				end
				pay_idx    = pay_idx + 3'd1;
				bytes_left = bytes_left - 3'd1;
				if (bytes_left != 3'd0) begin
					return;
				end
				if (is_rel(header)) begin
					btn    = header[1:0];
					dx_sum = dx_sum + {{8{pay0[7]}}, pay0};
					dy_sum = dy_sum + {{8{pay1[7]}}, pay1};
					if (btn != buttons) begin
						buttons = btn;
						push_event(KIND_BTN, {6'b0, btn}, '0, '0);
					end
				end else if (header == HDR_JOYS) begin
					push_event(KIND_JOY, pay1, '0, '0);
				end else if (header == HDR_JOY1) begin
					push_event(KIND_JOY, pay0, '0, '0);
				end
				return;
			end
			if (r.rx_byte >= HDR_STATUS) begin
				header     = r.rx_byte;
				pay_idx    = 3'd0;
				bytes_left = packet_length(r.rx_byte);
			end else begin
				push_event(KIND_KEY, r.rx_byte, '0, '0);
			end
		endfunction

		function void check_event(evt_t got);
			evt_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected event: kind %0d code 0x%02h", got.event_kind,
					got.event_code);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind: expected %0d, got %0d", want.event_kind,
					got.event_kind);
				errors++;
			end
			if (got.event_code !== want.event_code) begin
				$error("event_code: expected 0x%02h, got 0x%02h", want.event_code,
					got.event_code);
				errors++;
			end
			if (got.motion_dx !== want.motion_dx) begin
				$error("motion_dx: expected %0d, got %0d", want.motion_dx,
					got.motion_dx);
				errors++;
			end
			if (got.motion_dy !== want.motion_dy) begin
				$error("motion_dy: expected %0d, got %0d", want.motion_dy,
					got.motion_dy);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for keyboard_packet_parser. A directed sequence covers key
// bytes, mouse, joystick and status packets, harvests inside and outside
// packets and header bytes used as payload; a random mix of packets, keys,
// harvests and noise follows, then a run of mouse packets that builds up
// large motion totals. The sender works in bursts, the receiver stalls in
// changing patterns and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import kbp_pkg::*;
	import kbp_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 300;
	localparam int WRAP_PACKETS  = 90;
	localparam int HOLD_OFF      = 400;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic evt_valid;
	logic evt_stall;
	evt_t evt;

	kbp_event_tracker tracker = new();

	int cycles = 0;
	int items_sent;
	int burst_left;

	keyboard_packet_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				tracker.note_request(req);
			end
			if (evt_valid && !evt_stall) begin
				tracker.check_event(evt);
			end
		end
	end

	// receiver stall pattern, with one long hold-off early on
	initial begin : rx_side
		int stretch;
		int len;
		int pct;
		evt_stall = 1'b0;
		stretch = 0;
		wait (arst_n);
		forever begin
			stretch++;
			if (stretch == 4) begin
				@(posedge clk);
				evt_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
			end
			len = $urandom_range(10, 150);
			case ($urandom_range(0, 3))
				0:       pct = 0;
				1:       pct = 30;
				2:       pct = 60;
				default: pct = 90;
			endcase
			repeat (len) begin
				@(posedge clk);
				evt_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	task automatic send_req(input logic act, input logic [7:0] b);
		req_t r;
		int gap;
		r.action  = act;
		r.rx_byte = b;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		items_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(1, 6);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_req(ACT_BYTE, b);
	endtask

	task automatic send_harvest();
		send_req(ACT_HARVEST, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_packet(input logic [7:0] h);
		int n;
		n = kbp_event_tracker::packet_length(h);
		send_byte(h);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin : tx_side
		int sel;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req        = '0;
		items_sent = 0;
		burst_left = $urandom_range(1, 40);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		send_harvest();
		send_byte(8'h00);
		send_byte(HDR_STATUS - 8'd1);
		send_byte(HDR_REL_BASE);
		send_byte(8'h7F);
		send_byte(8'h80);
		send_byte(HDR_REL_BASE + 8'd1);
		send_byte(8'h80);
		send_harvest();
		send_byte(8'h7F);
		send_byte(HDR_REL_BASE + 8'd3);
		send_byte(8'h01);
		send_byte(8'hFF);
		send_byte(HDR_JOYS);
		send_byte(HDR_STATUS);
		send_byte(8'h12);
		send_byte(HDR_JOY1);
		send_byte(HDR_JOY1);
		send_byte(HDR_JOY0);
		send_byte(8'h00);
		send_byte(HDR_STATUS);
		send_byte(HDR_JOY1);
		send_byte(HDR_ABS);
		send_byte(HDR_CLOCK);
		send_byte(HDR_JOYS);
		send_byte(HDR_JOY0);
		send_byte(HDR_REL_BASE);
		send_byte(8'hA5);

		// random mix
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 30) begin
				send_byte(8'($urandom_range(0, HDR_STATUS - 8'd1)));
			end else if (sel < 40) begin
				send_harvest();
			end else if (sel < 75) begin
				send_packet(HDR_REL_BASE + 8'($urandom_range(0, 3)));
			end else if (sel < 83) begin
				send_packet(HDR_JOYS + 8'($urandom_range(0, 2)));
			end else if (sel < 90) begin
				case ($urandom_range(0, 2))
					0:       send_packet(HDR_STATUS);
					1:       send_packet(HDR_ABS);
					default: send_packet(HDR_CLOCK);
				endcase
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end

		// build up large totals
		send_harvest();
		repeat (WRAP_PACKETS) begin
			send_byte(HDR_REL_BASE + 8'($urandom_range(0, 3)));
			send_byte(8'($urandom_range(8'h78, 8'h7F)));
			send_byte(8'($urandom_range(8'h80, 8'h87)));
		end
		send_harvest();
		req_valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
